// File: sv/lrps_pkg.sv
// ----------------------------------------------------------------------------
// Line raster pixel stepper package
// Shared codes, constants and the control record passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package lrps_pkg;

    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int COLOR_BITS   = 32;
    localparam int ADDR_BITS    = 24;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SURFACE_WIDTH  = 1'b0,
        CFG_SURFACE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic last;
    } t_pix_ctl;

endpackage

`default_nettype wire

// File: sv/lrps_cfg.sv
// ----------------------------------------------------------------------------
// Surface configuration registers
// Holds the surface width and height and clamps them to the largest surface.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_cfg #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lrps_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [lrps_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic [lrps_pkg::CFG_BITS-1:0]      o_width,
    output logic [lrps_pkg::CFG_BITS-1:0]      o_height
);

    localparam int RegMax = (1 << lrps_pkg::CFG_BITS) - 1;
    localparam int DimCap = (MAX_DIM > RegMax) ? RegMax : MAX_DIM;
    localparam logic [lrps_pkg::CFG_BITS-1:0] Cap = lrps_pkg::CFG_BITS'(DimCap);

    logic [lrps_pkg::CFG_BITS-1:0] r_width;
    logic [lrps_pkg::CFG_BITS-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lrps_pkg::WIDTH_RESET;
            r_height <= lrps_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lrps_pkg::CFG_SURFACE_WIDTH:  r_width  <= i_cfg_data;
                lrps_pkg::CFG_SURFACE_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_width  = (r_width > Cap) ? Cap : r_width;
    assign o_height = (r_height > Cap) ? Cap : r_height;

endmodule

`default_nettype wire

// File: sv/lrps_engine.sv
// ----------------------------------------------------------------------------
// Line stepping engine
// Input register, line set-up on load and one Bresenham step per step word.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_engine #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_mode,
    input  wire logic signed [COORD_BITS-1:0]          i_start_x,
    input  wire logic signed [COORD_BITS-1:0]          i_start_y,
    input  wire logic signed [COORD_BITS-1:0]          i_end_x,
    input  wire logic signed [COORD_BITS-1:0]          i_end_y,
    input  wire logic [lrps_pkg::COLOR_BITS-1:0]       i_line_color,
    input  wire logic [lrps_pkg::CFG_BITS-1:0]         i_width,
    input  wire logic [lrps_pkg::CFG_BITS-1:0]         i_height,
    output lrps_pkg::t_pix_ctl                         o_ctl,
    output logic signed [COORD_BITS-1:0]               o_pixel_x,
    output logic signed [COORD_BITS-1:0]               o_pixel_y,
    output logic                                       o_in_bounds,
    output logic [lrps_pkg::ADDR_BITS-1:0]             o_pixel_address,
    output logic [lrps_pkg::COLOR_BITS-1:0]            o_pixel_color,
    input  wire logic                                  i_ready
);

    localparam int DW = COORD_BITS + 1;
    localparam int TW = COORD_BITS + 4;

    // Input register
    logic                              r_in_valid;
    logic                              r_mode;
    logic signed [COORD_BITS-1:0]      r_x0;
    logic signed [COORD_BITS-1:0]      r_y0;
    logic signed [COORD_BITS-1:0]      r_x1;
    logic signed [COORD_BITS-1:0]      r_y1;
    logic [lrps_pkg::COLOR_BITS-1:0]   r_color;

    // Line state
    logic                              r_active;
    logic                              r_steep;
    logic signed [COORD_BITS-1:0]      r_major;
    logic signed [COORD_BITS-1:0]      r_major_end;
    logic signed [COORD_BITS-1:0]      r_minor;
    logic                              r_minor_neg;
    logic signed [TW-1:0]              r_decision;
    logic signed [TW-1:0]              r_inc_pos;
    logic signed [TW-1:0]              r_inc_neg;
    logic [lrps_pkg::COLOR_BITS-1:0]   r_held_color;

    // Pixel register
    logic                              r_out_valid;
    logic                              r_out_last;
    logic signed [COORD_BITS-1:0]      r_out_x;
    logic signed [COORD_BITS-1:0]      r_out_y;
    logic                              r_out_inb;
    logic [lrps_pkg::ADDR_BITS-1:0]    r_out_addr;
    logic [lrps_pkg::COLOR_BITS-1:0]   r_out_color;

    logic                              w_out_free;
    logic                              w_fire;
    logic                              w_load;
    logic                              w_step;
    logic                              n_out_valid;

    logic signed [DW-1:0]              w_dx;
    logic signed [DW-1:0]              w_dy;
    logic [DW-1:0]                     w_adx;
    logic [DW-1:0]                     w_ady;
    logic                              w_steep;
    logic signed [COORD_BITS-1:0]      w_a0;
    logic signed [COORD_BITS-1:0]      w_b0;
    logic signed [COORD_BITS-1:0]      w_a1;
    logic signed [COORD_BITS-1:0]      w_b1;
    logic                              w_swap;
    logic signed [COORD_BITS-1:0]      w_maj0;
    logic signed [COORD_BITS-1:0]      w_maj1;
    logic signed [COORD_BITS-1:0]      w_min0;
    logic signed [COORD_BITS-1:0]      w_min1;
    logic signed [DW-1:0]              w_maj_d;
    logic signed [DW-1:0]              w_min_d;
    logic signed [DW-1:0]              w_min_abs;
    logic signed [TW-1:0]              w_two_m;
    logic signed [TW-1:0]              w_maj_t;

    logic                              w_last;
    logic                              w_dec_pos;
    logic signed [COORD_BITS-1:0]      w_px;
    logic signed [COORD_BITS-1:0]      w_py;
    logic                              w_inb;
    logic [lrps_pkg::ADDR_BITS-1:0]    w_addr;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign w_load     = w_fire && (r_mode == lrps_pkg::MODE_LOAD);
    assign w_step     = w_fire && (r_mode == lrps_pkg::MODE_STEP) && r_active;
    assign o_ready    = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode  <= i_mode;
            r_x0    <= i_start_x;
            r_y0    <= i_start_y;
            r_x1    <= i_end_x;
            r_y1    <= i_end_y;
            r_color <= i_line_color;
        end
    end

    // Line set-up
    always_comb begin
        w_dx    = DW'(r_x1) - DW'(r_x0);
        w_dy    = DW'(r_y1) - DW'(r_y0);
        w_adx   = w_dx[DW-1] ? -w_dx : w_dx;
        w_ady   = w_dy[DW-1] ? -w_dy : w_dy;
        w_steep = !(w_ady < w_adx);
        w_a0    = w_steep ? r_y0 : r_x0;
        w_b0    = w_steep ? r_x0 : r_y0;
        w_a1    = w_steep ? r_y1 : r_x1;
        w_b1    = w_steep ? r_x1 : r_y1;
        w_swap  = w_a0 > w_a1;
        w_maj0  = w_swap ? w_a1 : w_a0;
        w_maj1  = w_swap ? w_a0 : w_a1;
        w_min0  = w_swap ? w_b1 : w_b0;
        w_min1  = w_swap ? w_b0 : w_b1;
        w_maj_d = DW'(w_maj1) - DW'(w_maj0);
        w_min_d = DW'(w_min1) - DW'(w_min0);
        w_min_abs = w_min_d[DW-1] ? -w_min_d : w_min_d;
        w_two_m = TW'(w_min_abs) <<< 1;
        w_maj_t = TW'(w_maj_d);
    end

    // Step decision
    assign w_last    = r_major >= r_major_end;
    assign w_dec_pos = !r_decision[TW-1] && (r_decision != '0);

    // Current pixel, its bounds and its word address
    assign w_px = r_steep ? r_minor : r_major;
    assign w_py = r_steep ? r_major : r_minor;

    lrps_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_pixel_x       (w_px),
        .i_pixel_y       (w_py),
        .i_width         (i_width),
        .i_height        (i_height),
        .o_in_bounds     (w_inb),
        .o_pixel_address (w_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_load) begin
            r_active <= 1'b1;
        end else if (w_step && w_last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_steep      <= w_steep;
            r_major      <= w_maj0;
            r_major_end  <= w_maj1;
            r_minor      <= w_min0;
            r_minor_neg  <= w_min_d[DW-1];
            r_decision   <= w_two_m - w_maj_t;
            r_inc_pos    <= w_two_m;
            r_inc_neg    <= w_two_m - (w_maj_t <<< 1);
            r_held_color <= r_color;
        end else if (w_step && !w_last) begin
            r_major <= r_major + COORD_BITS'(1);
            if (w_dec_pos) begin
                r_minor    <= r_minor_neg ? (r_minor - COORD_BITS'(1))
                                          : (r_minor + COORD_BITS'(1));
                r_decision <= r_decision + r_inc_neg;
            end else begin
                r_decision <= r_decision + r_inc_pos;
            end
        end
    end

    // Pixel register
    assign n_out_valid = w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_x     <= w_px;
            r_out_y     <= w_py;
            r_out_inb   <= w_inb;
            r_out_addr  <= w_addr;
            r_out_color <= r_held_color;
            r_out_last  <= w_last;
        end
    end

    assign o_ctl.valid     = r_out_valid;
    assign o_ctl.last      = r_out_last;
    assign o_pixel_x       = r_out_x;
    assign o_pixel_y       = r_out_y;
    assign o_in_bounds     = r_out_inb;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_color   = r_out_color;

endmodule

`default_nettype wire

// File: sv/lrps_addr.sv
// ----------------------------------------------------------------------------
// Bounds check and address logic
// Tests the pixel against the surface and forms the word address x + y*width.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_addr #(
    parameter int COORD_BITS = 16
) (
    input  wire logic signed [COORD_BITS-1:0]          i_pixel_x,
    input  wire logic signed [COORD_BITS-1:0]          i_pixel_y,
    input  wire logic [lrps_pkg::CFG_BITS-1:0]         i_width,
    input  wire logic [lrps_pkg::CFG_BITS-1:0]         i_height,
    output logic                                       o_in_bounds,
    output logic [lrps_pkg::ADDR_BITS-1:0]             o_pixel_address
);

    localparam int CB = lrps_pkg::CFG_BITS;
    localparam int CW = (COORD_BITS > CB) ? COORD_BITS : CB;

    logic [CW-1:0]                       w_x_u;
    logic [CW-1:0]                       w_y_u;
    logic                                w_inb;
    logic [2*CB-1:0]                     w_prod;
    logic [lrps_pkg::ADDR_BITS-1:0]      w_addr;

    always_comb begin
        w_x_u  = CW'($unsigned(i_pixel_x));
        w_y_u  = CW'($unsigned(i_pixel_y));
        w_inb  = !i_pixel_x[COORD_BITS-1] && !i_pixel_y[COORD_BITS-1]
                 && (w_x_u < CW'(i_width)) && (w_y_u < CW'(i_height));
        w_prod = w_y_u[CB-1:0] * i_width;
        w_addr = w_prod[lrps_pkg::ADDR_BITS-1:0]
                 + lrps_pkg::ADDR_BITS'(w_x_u[CB-1:0]);
    end

    assign o_in_bounds     = w_inb;
    assign o_pixel_address = w_inb ? w_addr : '0;

endmodule

`default_nettype wire

// File: sv/line_raster_pixel_stepper.sv
// ----------------------------------------------------------------------------
// Line raster pixel stepper
// Bresenham line rasteriser: a load word sets up a line, each step word on
// an active line yields the next pixel, bounds flag, word address and colour.
//
//   Channel   Handshake            Direction  Carries
//   input     i_valid / o_ready    in         mode, endpoints, line colour
//   output    o_valid / i_ready    out        pixel, flags, address, colour
//   config    i_cfg_we             in         surface width and height
//
// One word is taken every cycle while the output is not stalled; a step
// word's pixel passes the input register, then the step, bounds check and
// address multiply into the result register, before it reaches the output.
// The rate is set by the step of the decision term.
// Reset is synchronous and active low and clears all valid flags and the
// active line. A stalled output stops the stages behind it only once each
// stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module line_raster_pixel_stepper #(
    parameter int COORD_BITS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_mode,
    input  wire logic signed [COORD_BITS-1:0]          i_start_x,
    input  wire logic signed [COORD_BITS-1:0]          i_start_y,
    input  wire logic signed [COORD_BITS-1:0]          i_end_x,
    input  wire logic signed [COORD_BITS-1:0]          i_end_y,
    input  wire logic [lrps_pkg::COLOR_BITS-1:0]       i_line_color,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [COORD_BITS-1:0]               o_pixel_x,
    output logic signed [COORD_BITS-1:0]               o_pixel_y,
    output logic                                       o_in_bounds,
    output logic [lrps_pkg::ADDR_BITS-1:0]             o_pixel_address,
    output logic [lrps_pkg::COLOR_BITS-1:0]            o_pixel_color,
    output logic                                       o_last_pixel,
    input  wire logic                                  i_cfg_we,
    input  wire logic [lrps_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [lrps_pkg::CFG_BITS-1:0]         i_cfg_data
);

    logic [lrps_pkg::CFG_BITS-1:0]     w_width;
    logic [lrps_pkg::CFG_BITS-1:0]     w_height;
    lrps_pkg::t_pix_ctl                w_ctl;

    lrps_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_width    (w_width),
        .o_height   (w_height)
    );

    lrps_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_line_color    (i_line_color),
        .i_width         (w_width),
        .i_height        (w_height),
        .o_ctl           (w_ctl),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_in_bounds     (o_in_bounds),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .i_ready         (i_ready)
    );

    assign o_valid      = w_ctl.valid;
    assign o_last_pixel = w_ctl.last;

endmodule

`default_nettype wire

// File: sv/lrps_checker.sv
// ----------------------------------------------------------------------------
// Line raster pixel stepper port checker
// Watches the output word and reset behaviour on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_checker #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  o_valid,
    input  wire logic                                  i_ready,
    input  wire logic signed [COORD_BITS-1:0]          o_pixel_x,
    input  wire logic signed [COORD_BITS-1:0]          o_pixel_y,
    input  wire logic                                  o_in_bounds,
    input  wire logic [lrps_pkg::ADDR_BITS-1:0]        o_pixel_address,
    input  wire logic [lrps_pkg::COLOR_BITS-1:0]       o_pixel_color,
    input  wire logic                                  o_last_pixel
);

    // A stalled output word must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable({o_pixel_x, o_pixel_y, o_in_bounds,
                                          o_pixel_address, o_pixel_color,
                                          o_last_pixel}))
        else $error("output word changed while stalled");

    // A pixel off the surface carries a zero address.
    a_oob_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_bounds |-> o_pixel_address == '0)
        else $error("out-of-bounds pixel with non-zero address");

    // A pixel on the surface never has a negative coordinate.
    a_inb_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_bounds |-> !o_pixel_x[COORD_BITS-1] && !o_pixel_y[COORD_BITS-1])
        else $error("in-bounds pixel with negative coordinate");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule

bind line_raster_pixel_stepper lrps_checker #(
    .COORD_BITS (COORD_BITS)
) u_lrps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_in_bounds     (o_in_bounds),
    .o_pixel_address (o_pixel_address),
    .o_pixel_color   (o_pixel_color),
    .o_last_pixel    (o_last_pixel)
);

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Line raster pixel stepper testbench
// Drives load and step words into the rasteriser under random idling on both
// channels, predicts every pixel with an independent Bresenham model and
// compares each emitted pixel field by field. Surface width and height are
// rewritten between phases while the block is idle, extremes included.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_W       = 16;
    localparam int DIM_MAX       = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 110;

    typedef struct packed {
        lrps_pkg::t_mode                 mode;
        logic [COORD_W-1:0]              sx;
        logic [COORD_W-1:0]              sy;
        logic [COORD_W-1:0]              ex;
        logic [COORD_W-1:0]              ey;
        logic [lrps_pkg::COLOR_BITS-1:0] color;
    } t_line_word;

    typedef struct packed {
        logic [COORD_W-1:0]              x;
        logic [COORD_W-1:0]              y;
        logic                            inb;
        logic [lrps_pkg::ADDR_BITS-1:0]  addr;
        logic [lrps_pkg::COLOR_BITS-1:0] color;
        logic                            last;
    } t_pixel;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic                                in_mode   = 1'b0;
    logic [COORD_W-1:0]                  in_sx     = '0;
    logic [COORD_W-1:0]                  in_sy     = '0;
    logic [COORD_W-1:0]                  in_ex     = '0;
    logic [COORD_W-1:0]                  in_ey     = '0;
    logic [lrps_pkg::COLOR_BITS-1:0]     in_color  = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [COORD_W-1:0]                  pix_x;
    logic [COORD_W-1:0]                  pix_y;
    logic                                pix_inb;
    logic [lrps_pkg::ADDR_BITS-1:0]      pix_addr;
    logic [lrps_pkg::COLOR_BITS-1:0]     pix_color;
    logic                                pix_last;
    logic                                cfg_we    = 1'b0;
    logic [lrps_pkg::CFG_IDX_BITS-1:0]   cfg_idx   = '0;
    logic [lrps_pkg::CFG_BITS-1:0]       cfg_data  = '0;

    t_line_word pending_words[$];
    t_pixel     predicted_pixels[$];
    t_line_word cur_word;
    t_pixel     seen_px;
    t_pixel     want_px;
    int         words_queued = 0;
    int         words_taken  = 0;
    int         mismatches   = 0;
    int         src_pct      = 15;
    int         snk_pct      = 15;
    int         src_gap      = 0;
    int         snk_gap      = 0;

    logic [lrps_pkg::CFG_BITS-1:0] surf_width  = lrps_pkg::WIDTH_RESET;
    logic [lrps_pkg::CFG_BITS-1:0] surf_height = lrps_pkg::HEIGHT_RESET;

    logic       ln_active = 1'b0;
    logic       ln_steep  = 1'b0;
    logic       min_neg   = 1'b0;
    int         maj_pos   = 0;
    int         maj_stop  = 0;
    int         min_pos   = 0;
    int         dec_term  = 0;
    int         maj_delta = 0;
    int         min_delta = 0;
    logic [lrps_pkg::COLOR_BITS-1:0] ln_color = '0;

    line_raster_pixel_stepper #(
        .COORD_BITS(COORD_W),
        .MAX_DIM   (DIM_MAX)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_mode         (in_mode),
        .i_start_x      (in_sx),
        .i_start_y      (in_sy),
        .i_end_x        (in_ex),
        .i_end_y        (in_ey),
        .i_line_color   (in_color),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_pixel_x      (pix_x),
        .o_pixel_y      (pix_y),
        .o_in_bounds    (pix_inb),
        .o_pixel_address(pix_addr),
        .o_pixel_color  (pix_color),
        .o_last_pixel   (pix_last),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_dim(input logic [lrps_pkg::CFG_BITS-1:0] v);
        return (int'(v) > DIM_MAX) ? DIM_MAX : int'(v);
    endfunction

    task automatic rasterize_word(input t_line_word w);
        int x0, y0, x1, y1, a0, b0, a1, b1, t, dmin, px, py, wd, ht;
        t_pixel p;
        if (w.mode == lrps_pkg::MODE_LOAD) begin
            x0 = int'($signed(w.sx));
            y0 = int'($signed(w.sy));
            x1 = int'($signed(w.ex));
            y1 = int'($signed(w.ey));
            ln_steep = !(mag(y1 - y0) < mag(x1 - x0));
            if (ln_steep) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            if (a0 > a1) begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            maj_pos   = a0;
            maj_stop  = a1;
            min_pos   = b0;
            maj_delta = a1 - a0;
            dmin      = b1 - b0;
            min_neg   = dmin < 0;
            min_delta = mag(dmin);
            dec_term  = 2 * min_delta - maj_delta;
            ln_color  = w.color;
            ln_active = 1'b1;
        end else if (ln_active) begin
            px = ln_steep ? min_pos : maj_pos;
            py = ln_steep ? maj_pos : min_pos;
            wd = clamp_dim(surf_width);
            ht = clamp_dim(surf_height);
            p.x     = COORD_W'(px);
            p.y     = COORD_W'(py);
            p.inb   = px >= 0 && py >= 0 && px < wd && py < ht;
            p.addr  = p.inb ? lrps_pkg::ADDR_BITS'(px + py * wd) : '0;
            p.color = ln_color;
            p.last  = maj_pos >= maj_stop;
            predicted_pixels.push_back(p);
            if (p.last) begin
                ln_active = 1'b0;
            end else begin
                if (dec_term > 0) begin
                    min_pos  = min_neg ? min_pos - 1 : min_pos + 1;
                    dec_term = dec_term - 2 * maj_delta;
                end
                dec_term = dec_term + 2 * min_delta;
                maj_pos  = maj_pos + 1;
            end
        end
    endtask

    task automatic push_word(input lrps_pkg::t_mode m, input int sx, input int sy,
                             input int ex, input int ey,
                             input logic [lrps_pkg::COLOR_BITS-1:0] color);
        t_line_word w;
        w.mode  = m;
        w.sx    = COORD_W'(sx);
        w.sy    = COORD_W'(sy);
        w.ex    = COORD_W'(ex);
        w.ey    = COORD_W'(ey);
        w.color = color;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_random_lines(input int n_words);
        int wd, ht, sx, sy, dx, dy, span, steps, added, kind;
        added = 0;
        wd = clamp_dim(surf_width);
        ht = clamp_dim(surf_height);
        while (added < n_words) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                sx = int'($urandom_range(0, wd + 16)) - 8;
                sy = int'($urandom_range(0, ht + 16)) - 8;
                dx = int'($urandom_range(0, 24)) - 12;
                dy = int'($urandom_range(0, 24)) - 12;
                if (kind == 7) begin
                    dy = $urandom_range(0, 1) ? dx : -dx;
                    if ($urandom_range(0, 3) == 0) begin
                        dx = 0;
                        dy = 0;
                    end
                end
                span  = ((mag(dx) > mag(dy)) ? mag(dx) : mag(dy)) + 1;
                steps = span;
                if (kind == 0) begin
                    steps = span + $urandom_range(1, 3);
                end else if (kind == 1) begin
                    steps = $urandom_range(0, span - 1);
                end
                push_word(lrps_pkg::MODE_LOAD, sx, sy, sx + dx, sy + dy, $urandom());
            end else begin
                steps = $urandom_range(0, 4);
                push_word(lrps_pkg::MODE_LOAD, $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom());
            end
            added++;
            repeat (steps) begin
                push_word(lrps_pkg::MODE_STEP, $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom());
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (!(words_taken == words_queued && predicted_pixels.size() == 0)) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input lrps_pkg::t_cfg_idx idx, input int value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= lrps_pkg::CFG_BITS'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lrps_pkg::CFG_SURFACE_WIDTH) begin
            surf_width = lrps_pkg::CFG_BITS'(value);
        end else begin
            surf_height = lrps_pkg::CFG_BITS'(value);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                rasterize_word(cur_word);
                words_taken++;
            end
            if (!in_valid || in_ready) begin
                if (src_gap == 0 && src_pct != 0 && $urandom_range(1, 100) <= src_pct) begin
                    src_gap = $urandom_range(1, 12);
                end
                if (src_gap > 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    in_mode  <= cur_word.mode;
                    in_sx    <= cur_word.sx;
                    in_sy    <= cur_word.sy;
                    in_ex    <= cur_word.ex;
                    in_ey    <= cur_word.ey;
                    in_color <= cur_word.color;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (out_valid && out_ready) begin
                seen_px.x     = pix_x;
                seen_px.y     = pix_y;
                seen_px.inb   = pix_inb;
                seen_px.addr  = pix_addr;
                seen_px.color = pix_color;
                seen_px.last  = pix_last;
                if (predicted_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch: unexpected pixel x=%0d y=%0d",
                                 $signed(seen_px.x), $signed(seen_px.y));
                    end
                end else begin
                    want_px = predicted_pixels.pop_front();
                    if (seen_px.x !== want_px.x || seen_px.y !== want_px.y ||
                        seen_px.inb !== want_px.inb || seen_px.addr !== want_px.addr ||
                        seen_px.color !== want_px.color || seen_px.last !== want_px.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("mismatch: exp x=%0d y=%0d inb=%0b addr=%0d col=%h last=%0b",
                                     $signed(want_px.x), $signed(want_px.y), want_px.inb,
                                     want_px.addr, want_px.color, want_px.last);
                            $display("          act x=%0d y=%0d inb=%0b addr=%0d col=%h last=%0b",
                                     $signed(seen_px.x), $signed(seen_px.y), seen_px.inb,
                                     seen_px.addr, seen_px.color, seen_px.last);
                        end
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                out_ready <= 1'b0;
            end else if (snk_pct != 0 && $urandom_range(1, 100) <= snk_pct) begin
                snk_gap = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int ph_w[PHASES];
        int ph_h[PHASES];
        int pick[3];
        ph_w = '{1, 4096, 8191, 0, 4097, 0, 0, 640};
        ph_h = '{1, 4096, 8191, 4096, 0, 0, 0, 480};
        ph_w[5] = $urandom_range(1, DIM_MAX);
        ph_h[5] = $urandom_range(1, DIM_MAX);
        ph_w[6] = $urandom_range(0, 8191);
        ph_h[6] = $urandom_range(0, 8191);
        pick = '{0, 8, 25};

        push_word(lrps_pkg::MODE_STEP, 0, 0, 0, 0, '0);
        push_word(lrps_pkg::MODE_LOAD, 5, 5, 5, 5, 32'hFFFF_FFFF);
        repeat (2) push_word(lrps_pkg::MODE_STEP, 0, 0, 0, 0, '0);
        push_word(lrps_pkg::MODE_LOAD, 3, 0, 0, 3, 32'h1234_5678);
        repeat (4) push_word(lrps_pkg::MODE_STEP, 0, 0, 0, 0, '0);
        push_word(lrps_pkg::MODE_LOAD, -32768, -32768, 32767, 32767, 32'h0);
        repeat (2) push_word(lrps_pkg::MODE_STEP, -1, -1, -1, -1, 32'hFFFF_FFFF);
        push_word(lrps_pkg::MODE_LOAD, 32767, -32768, -32768, 32767, 32'hA5A5_A5A5);
        push_word(lrps_pkg::MODE_STEP, 0, 0, 0, 0, '0);
        push_word(lrps_pkg::MODE_LOAD, 637, 479, 640, 478, 32'h5A5A_5A5A);
        repeat (4) push_word(lrps_pkg::MODE_STEP, 0, 0, 0, 0, '0);
        push_word(lrps_pkg::MODE_LOAD, 0, -1, -1, 2, 32'h0F0F_0F0F);
        repeat (4) push_word(lrps_pkg::MODE_STEP, 0, 0, 0, 0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_reg(lrps_pkg::CFG_SURFACE_WIDTH, ph_w[ph]);
            write_reg(lrps_pkg::CFG_SURFACE_HEIGHT, ph_h[ph]);
            if (ph == PHASES - 1) begin
                src_pct = 0;
                snk_pct = 0;
            end else begin
                src_pct = pick[$urandom_range(0, 2)];
                snk_pct = pick[$urandom_range(0, 2)];
            end
            queue_random_lines(PHASE_WORDS);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
